// ----- design/dra_pkg.sv -----
// ----------------------------------------------------------------------------
// dra_pkg
// Shared types and constants of the descending rank assigner: transfer
// payloads, the token and slot records that move along the cell chain,
// and the award codes.
// ----------------------------------------------------------------------------
package dra_pkg;

    // default configuration
    localparam int DEF_MAX_ITEMS  = 64;
    localparam int DEF_SCORE_BITS = 32;

    // fixed field widths
    localparam int IN_SCORE_W = 32;
    localparam int IDX_W      = 6;
    localparam int RANK_W     = 7;
    localparam int AWARD_W    = 2;

    // award codes
    localparam logic [AWARD_W-1:0] AWARD_NONE   = 2'd0;
    localparam logic [AWARD_W-1:0] AWARD_GOLD   = 2'd1;
    localparam logic [AWARD_W-1:0] AWARD_SILVER = 2'd2;
    localparam logic [AWARD_W-1:0] AWARD_BRONZE = 2'd3;

    // input transfer payload
    typedef struct packed {
        logic signed [IN_SCORE_W-1:0] score_value;
        logic                         last_score;
    } t_in_item;

    // output transfer payload
    typedef struct packed {
        logic [IDX_W-1:0]   original_index;
        logic [RANK_W-1:0]  rank_place;
        logic [AWARD_W-1:0] award_code;
        logic               overflow_seen;
        logic               last_result;
    } t_out_item;

    // control part of a score token travelling down the chain
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] above;
    } t_tok;

    // control part of a cell's stored entry
    typedef struct packed {
        logic             occupied;
        logic [IDX_W-1:0] count;
    } t_slot;

endpackage

// ----- design/descending_rank_assigner.sv -----
// ----------------------------------------------------------------------------
// descending_rank_assigner
// Loads a set of signed scores and reports, in load order, each score's
// 1-based place in descending order with an award code. Ties go to the
// earlier score. Scores beyond capacity are dropped and flagged.
//
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+---------------------------
// in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
// out     | output    | o_out_valid/ i_out_stall| o_out_data (t_out_item)
//
// Scores are taken one per cycle; each enters a token that walks the cell
// chain one cell per cycle. After the last-marked score the input stalls
// while the chain drains, then one result leaves per cycle unless the
// output is stalled.
// Reset clears the occupied flags, tokens and control; scores need none.
// A stalled output holds its register and pauses the unload shift.
// ----------------------------------------------------------------------------
module descending_rank_assigner #(
    parameter int MAX_ITEMS  = dra_pkg::DEF_MAX_ITEMS,
    parameter int SCORE_BITS = dra_pkg::DEF_SCORE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dra_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dra_pkg::t_out_item o_out_data
);
    import dra_pkg::*;

    localparam int LCNT_W = $clog2(MAX_ITEMS + 1);

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_DRAIN  = 2'd1;
    localparam logic [1:0] ST_UNLOAD = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [LCNT_W-1:0]            r_loaded, n_loaded;
    logic                         r_dropped, n_dropped;
    logic [IDX_W-1:0]             r_out_idx, n_out_idx;
    t_tok                         r_tok, n_tok;
    logic signed [SCORE_BITS-1:0] r_tok_score;
    logic                         r_out_valid, n_out_valid;
    t_out_item                    r_out, n_out;

    logic                         in_acc;
    logic                         full;
    logic                         out_load;
    logic                         shift;
    logic                         chain_busy;
    logic signed [SCORE_BITS-1:0] key;
    logic [RANK_W-1:0]            rank;

    t_tok                         tok [0:MAX_ITEMS];
    logic signed [SCORE_BITS-1:0] tok_score [0:MAX_ITEMS];
    t_slot                        slot [0:MAX_ITEMS];
    logic signed [SCORE_BITS-1:0] slot_score [0:MAX_ITEMS];

    // input handshake
    assign o_in_stall = (r_state != ST_LOAD);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign full       = (r_loaded == LCNT_W'(MAX_ITEMS));

    // comparison key: low SCORE_BITS bits, or the sign-extended score
    assign key = SCORE_BITS'(i_in_data.score_value);

    // unload handshake
    assign out_load = (r_state == ST_UNLOAD) && (!r_out_valid || !i_out_stall);
    assign shift    = out_load;

    // cell chain
    assign tok[0]                = r_tok;
    assign tok_score[0]          = r_tok_score;
    assign slot[MAX_ITEMS]       = '0;
    assign slot_score[MAX_ITEMS] = '0;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        dra_cell #(
            .SCORE_BITS (SCORE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (shift),
            .i_tok        (tok[g]),
            .i_tok_score  (tok_score[g]),
            .i_nbr        (slot[g+1]),
            .i_nbr_score  (slot_score[g+1]),
            .o_tok        (tok[g+1]),
            .o_tok_score  (tok_score[g+1]),
            .o_slot       (slot[g]),
            .o_slot_score (slot_score[g])
        );
    end

    // any token still walking the chain
    always_comb begin
        chain_busy = r_tok.valid;
        for (int k = 1; k <= MAX_ITEMS; k++) begin
            chain_busy = chain_busy | tok[k].valid;
        end
    end

    // place of the head entry
    assign rank = RANK_W'(slot[0].count) + 1'b1;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_dropped   = r_dropped;
        n_out_idx   = r_out_idx;
        n_tok       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_tok.valid = 1'b1;
                        n_loaded    = r_loaded + 1'b1;
                    end
                    if (i_in_data.last_score) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!chain_busy) begin
                    n_state   = ST_UNLOAD;
                    n_out_idx = '0;
                end
            end
            ST_UNLOAD: begin
                if (out_load) begin
                    n_out_valid              = 1'b1;
                    n_out.original_index     = r_out_idx;
                    n_out.rank_place         = rank;
                    n_out.overflow_seen      = r_dropped;
                    n_out.last_result        = !slot[1].occupied;
                    case (rank)
                        RANK_W'(1): n_out.award_code = AWARD_GOLD;
                        RANK_W'(2): n_out.award_code = AWARD_SILVER;
                        RANK_W'(3): n_out.award_code = AWARD_BRONZE;
                        default:    n_out.award_code = AWARD_NONE;
                    endcase
                    n_out_idx = r_out_idx + 1'b1;
                    if (!slot[1].occupied) begin
                        n_state   = ST_LOAD;
                        n_loaded  = '0;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        r_tok.above <= n_tok.above;
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_loaded    <= '0;
            r_dropped   <= 1'b0;
            r_tok.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_dropped   <= n_dropped;
            r_tok.valid <= n_tok.valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_idx   <= n_out_idx;
        r_tok_score <= key;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- design/dra_cell.sv -----
// ----------------------------------------------------------------------------
// dra_cell
// One cell of the ranking chain. Holds one stored score and the number of
// scores ranked above it. A passing token is compared against the stored
// score; an empty cell takes the token in. During unload the cell copies
// its downstream neighbor's entry.
// ----------------------------------------------------------------------------
module dra_cell #(
    parameter int SCORE_BITS = dra_pkg::DEF_SCORE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  dra_pkg::t_tok                i_tok,
    input  logic signed [SCORE_BITS-1:0] i_tok_score,
    input  dra_pkg::t_slot               i_nbr,
    input  logic signed [SCORE_BITS-1:0] i_nbr_score,
    output dra_pkg::t_tok                o_tok,
    output logic signed [SCORE_BITS-1:0] o_tok_score,
    output dra_pkg::t_slot               o_slot,
    output logic signed [SCORE_BITS-1:0] o_slot_score
);
    import dra_pkg::*;

    t_slot                         r_slot, n_slot;
    logic signed [SCORE_BITS-1:0]  r_score, n_score;
    t_tok                          r_tok, n_tok;
    logic signed [SCORE_BITS-1:0]  r_tok_score;
    logic                          beats;

    // new score strictly above the stored one
    assign beats = i_tok_score > r_score;

    // compare, land or shift
    always_comb begin
        n_slot  = r_slot;
        n_score = r_score;
        n_tok   = i_tok;
        if (i_shift) begin
            n_slot    = i_nbr;
            n_score   = i_nbr_score;
            n_tok.valid = 1'b0;
        end else if (i_tok.valid) begin
            if (r_slot.occupied) begin
                if (beats) begin
                    n_slot.count = r_slot.count + 1'b1;
                end else begin
                    n_tok.above = i_tok.above + 1'b1;
                end
            end else begin
                n_slot.occupied = 1'b1;
                n_slot.count    = i_tok.above;
                n_score         = i_tok_score;
                n_tok.valid     = 1'b0;
            end
        end
    end

    // slot and token records; only the flags take reset
    always_ff @(posedge i_clk) begin
        r_slot.count <= n_slot.count;
        r_tok.above  <= n_tok.above;
        if (!i_rst_n) begin
            r_slot.occupied <= 1'b0;
            r_tok.valid     <= 1'b0;
        end else begin
            r_slot.occupied <= n_slot.occupied;
            r_tok.valid     <= n_tok.valid;
        end
    end

    // scores
    always_ff @(posedge i_clk) begin
        r_score      <= n_score;
        r_tok_score  <= i_tok_score;
    end

    assign o_tok        = r_tok;
    assign o_tok_score  = r_tok_score;
    assign o_slot       = r_slot;
    assign o_slot_score = r_score;

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the descending rank assigner. Score sets are
// streamed in, directed corner sets first, then random sets of mixed size,
// including a full set and a set that overflows capacity. A scoreboard keeps
// its own ranking of each set and checks every result transfer in order.
// Sender gaps and receiver stalls vary across several phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dra_pkg::*;

    localparam int MAX_ITEMS   = DEF_MAX_ITEMS;
    localparam int SCORE_BITS  = DEF_SCORE_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [IN_SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [IN_SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

    // ranking scoreboard: keeps the loaded set and the expected results
    class rank_scoreboard;
        logic signed [IN_SCORE_W-1:0] scores[MAX_ITEMS];
        logic [IDX_W-1:0]             outranked[MAX_ITEMS];
        int unsigned                  loaded;
        bit                           dropped;
        t_out_item                    expected_q[$];
        int                           error_count;
        int                           result_count;

        function new();
            loaded       = 0;
            dropped      = 0;
            error_count  = 0;
            result_count = 0;
        endfunction

        task report(input string msg);
            error_count++;
            $display("ERROR: result %0d: %s", result_count, msg);
        endtask

        function logic [AWARD_W-1:0] award_for(input logic [RANK_W-1:0] place);
            case (place)
                7'd1:    return AWARD_GOLD;
                7'd2:    return AWARD_SILVER;
                7'd3:    return AWARD_BRONZE;
                default: return AWARD_NONE;
            endcase
        endfunction

        // an accepted score: update the counts, emit the set on a last mark
        function void note_input(input t_in_item item);
            logic signed [IN_SCORE_W-1:0] value;
            logic [IDX_W-1:0]             above;
            logic [RANK_W-1:0]            place;
            t_out_item                    res;
            value = item.score_value;
            if (loaded < MAX_ITEMS) begin
                above = '0;
                for (int i = 0; i < loaded; i++) begin
                    if (value > scores[i])
                        outranked[i] = outranked[i] + 1'b1;
                    else
                        above = above + 1'b1;
                end
                scores[loaded]    = value;
                outranked[loaded] = above;
                loaded++;
            end else begin
                dropped = 1'b1;
            end
            if (item.last_score) begin
                for (int i = 0; i < loaded; i++) begin
                    place              = RANK_W'(outranked[i]) + 1'b1;
                    res.original_index = IDX_W'(i);
                    res.rank_place     = place;
                    res.award_code     = award_for(place);
                    res.overflow_seen  = dropped;
                    res.last_result    = (i + 1 == loaded);
                    expected_q.push_back(res);
                end
                loaded  = 0;
                dropped = 1'b0;
            end
        endfunction

        // an accepted result: compare with the oldest expectation
        task check_result(input t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report("result transfer with nothing expected");
            end else begin
                want = expected_q.pop_front();
                if (got.original_index !== want.original_index)
                    report($sformatf("index got %0d want %0d",
                                     got.original_index, want.original_index));
                if (got.rank_place !== want.rank_place)
                    report($sformatf("rank got %0d want %0d (index %0d)",
                                     got.rank_place, want.rank_place,
                                     want.original_index));
                if (got.award_code !== want.award_code)
                    report($sformatf("award got %0d want %0d (index %0d)",
                                     got.award_code, want.award_code,
                                     want.original_index));
                if (got.overflow_seen !== want.overflow_seen)
                    report($sformatf("overflow got %0b want %0b (index %0d)",
                                     got.overflow_seen, want.overflow_seen,
                                     want.original_index));
                if (got.last_result !== want.last_result)
                    report($sformatf("last got %0b want %0b (index %0d)",
                                     got.last_result, want.last_result,
                                     want.original_index));
            end
            result_count++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    rank_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    descending_rank_assigner #(
        .MAX_ITEMS  (MAX_ITEMS),
        .SCORE_BITS (SCORE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_data);
    end

    // one score transfer, with optional idle cycles ahead of it
    task automatic send_score(input logic signed [IN_SCORE_W-1:0] value,
                              input logic last);
        t_in_item item;
        bit       taken;
        item.score_value = value;
        item.last_score  = last;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_in_stall;
            if (taken)
                sb.note_input(item);
            @(negedge i_clk);
        end
    endtask

    // random score: mostly full range, some extremes, some tie-heavy values
    function automatic logic signed [IN_SCORE_W-1:0] pick_score();
        int sel;
        int near;
        sel = $urandom_range(9);
        case (sel)
            0:       return SCORE_MAX;
            1:       return SCORE_MIN;
            2, 3: begin
                near = $urandom_range(6);
                return near - 3;
            end
            default: return $urandom;
        endcase
    endfunction

    // a whole set of random scores, last mark on the final one
    task automatic send_set(input int size);
        for (int k = 0; k < size; k++)
            send_score(pick_score(), k == size - 1);
    endtask

    initial begin
        int phase_items;
        int size;
        sb = new();

        // reset
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single score at the bottom of the range
        send_score(SCORE_MIN, 1'b1);
        // extremes mixed with zero and plus or minus one
        send_score(SCORE_MAX, 1'b0);
        send_score(SCORE_MIN, 1'b0);
        send_score(32'sd0, 1'b0);
        send_score(-32'sd1, 1'b0);
        send_score(32'sd1, 1'b1);
        // all equal scores, places go by load order
        repeat (3) send_score(32'sd7, 1'b0);
        send_score(32'sd7, 1'b1);
        // ascending set, best score last
        for (int v = -3; v <= 1; v++)
            send_score(v, v == 1);
        // alternating bit patterns
        send_score(32'sh5555_5555, 1'b0);
        send_score(32'shAAAA_AAAA, 1'b1);

        // random sets over the idling phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            phase_items = 0;
            while (phase_items < 45) begin
                size = ($urandom_range(9) == 0) ? $urandom_range(9, 24)
                                                : $urandom_range(1, 8);
                send_set(size);
                phase_items += size;
            end
            // full set, then a set that spills past capacity
            if (phase == 1)
                send_set(MAX_ITEMS);
            if (phase == 3)
                send_set($urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4));
        end
        i_in_valid <= 1'b0;

        // drain
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (2 * MAX_ITEMS + 8) @(posedge i_clk);

        if (sb.error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/dra_pkg.sv
design/dra_cell.sv
design/descending_rank_assigner.sv
verif/testbench.sv
